[rtl/tgse_pkg.sv]
// Shared constants and types for the text grid screen editor.
// No dependencies; imported by text_grid_screen_editor.
`default_nettype none
package tgse_pkg;

  // default geometry and reset value of the view height register
  localparam int GRID_ROWS_DEF = 360;
  localparam int GRID_COLS_DEF = 96;
  localparam int PAGE_STEP_DEF = 20;
  localparam int VIS_RESET     = 20;

  // key and character codes
  localparam logic [7:0] KEY_ESC   = 8'h1b;
  localparam logic [7:0] KEY_BRK   = 8'h03;
  localparam logic [7:0] KEY_BS    = 8'h08;
  localparam logic [7:0] KEY_DEL   = 8'h7f;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_LAST   = 8'h7e;
  localparam logic [7:0] CH_CR     = 8'h0d;
  localparam logic [7:0] CH_LF     = 8'h0a;
  localparam logic [7:0] CH_LBRACK = 8'h5b;

  // navigation bytes following ESC [
  localparam logic [7:0] NAV_UP    = 8'h41;
  localparam logic [7:0] NAV_DOWN  = 8'h42;
  localparam logic [7:0] NAV_RIGHT = 8'h43;
  localparam logic [7:0] NAV_LEFT  = 8'h44;
  localparam logic [7:0] NAV_END   = 8'h46;
  localparam logic [7:0] NAV_HOME  = 8'h48;
  localparam logic [7:0] NAV_PGUP  = 8'h35;
  localparam logic [7:0] NAV_PGDN  = 8'h36;

  localparam logic [6:0] CELL_SPACE = 7'h20;

  typedef enum logic [1:0] {
    ACT_KEY, ACT_PUT, ACT_READ, ACT_CLEAR
  } action_t;

  typedef enum logic [1:0] {
    ESC_NONE, ESC_SEEN, ESC_CSI
  } esc_t;

  typedef enum logic [3:0] {
    S_CLEAR, S_IDLE, S_DECODE, S_SHIFT, S_PUT, S_SCAN, S_SCROLL, S_READ, S_DONE
  } state_t;

  // what follows a row scan or a scroll
  typedef enum logic [1:0] {
    OP_END, OP_ENTER, OP_PRINT, OP_LINE
  } op_t;

endpackage
`default_nettype wire

[rtl/text_grid_screen_editor.sv]
// Text grid screen editor: key parser, cursor, grid RAM with ring-based scroll; uses tgse_pkg.
// Cursor-only items go from decode straight to the result, cell reads through a read state;
// insert, backspace, Enter and End take one row walk, and a scroll adds a walk blanking a row.
// Clear writes a space to all GRID_ROWS * 2**clog2(GRID_COLS) RAM cells. One item at a time:
// the next transfer is taken only after the result is issued; the row walk through the RAM port
// sets the rate. Reset (rst, synchronous) runs the same clearing pass.
`default_nettype none
module text_grid_screen_editor #(
  parameter int GRID_ROWS = tgse_pkg::GRID_ROWS_DEF,
  parameter int GRID_COLS = tgse_pkg::GRID_COLS_DEF,
  parameter int PAGE_STEP = tgse_pkg::PAGE_STEP_DEF,
  localparam int RW = $clog2(GRID_ROWS),
  localparam int PW = $clog2(GRID_COLS + 1),
  localparam int VW = $clog2(GRID_ROWS + 1),
  localparam int IN_W = ((8 + RW + PW + 7) / 8) * 8,
  localparam int OUT_W = ((3 * RW + 2 * PW + 7 + 7) / 8) * 8
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             cfg_wen,
  input  wire logic [VW-1:0]    cfg_wdata,  // rows in view
  input  wire logic             s_tvalid,
  output logic                  s_tready,
  // char_code, cell_row, cell_col
  input  wire logic [IN_W-1:0]  s_tdata,
  input  wire logic [1:0]       s_tuser,    // action
  output logic                  m_tvalid,
  input  wire logic             m_tready,
  // cursor_row, cursor_col, view_row, line_row, line_length, cell_char
  output logic [OUT_W-1:0]      m_tdata,
  output logic [0:0]            m_tuser     // line_submitted
);
  import tgse_pkg::*;

  localparam int CW    = (GRID_COLS > 1) ? $clog2(GRID_COLS) : 1;
  localparam int AW    = RW + CW;
  localparam int DEPTH = GRID_ROWS * (2 ** CW);
  localparam int EW    = ((VW > RW) ? VW : RW) + 1;

  localparam logic [RW-1:0] ROW_LAST  = RW'(GRID_ROWS - 1);
  localparam logic [PW-1:0] COLS_P    = PW'(GRID_COLS);
  localparam logic [PW-1:0] COL_LASTP = PW'(GRID_COLS - 1);
  localparam logic [CW-1:0] COL_LASTC = CW'(GRID_COLS - 1);
  localparam logic [AW-1:0] ADDR_LAST = AW'(DEPTH - 1);

  // ring-relative row to physical row
  function automatic logic [RW-1:0] phys(input logic [RW-1:0] base,
                                         input logic [RW-1:0] r);
    logic [RW:0] s;
    s = {1'b0, base} + {1'b0, r};
    if (s >= (RW+1)'(GRID_ROWS)) s = s - (RW+1)'(GRID_ROWS);
    return s[RW-1:0];
  endfunction

  state_t state, state_next;
  op_t    op;
  esc_t   phase;

  logic [VW-1:0] vis;
  logic [RW-1:0] ring_base, row, view;
  logic [PW-1:0] col;
  action_t       act;
  logic [7:0]    ch;
  logic [RW-1:0] rr;
  logic [PW-1:0] rc;

  // row walk engine
  logic [CW-1:0] idx, idx_end, pend_col, put_col, sc_col;
  logic          up, idx_last, pend;
  logic [6:0]    put_char;
  logic [PW-1:0] scan_len;
  logic [RW-1:0] scroll_row;
  logic [AW-1:0] clr_addr;
  logic          clr_reply;

  logic          res_sub;
  logic [RW-1:0] res_lrow;
  logic [PW-1:0] res_llen;
  logic [6:0]    res_cell;

  // grid RAM
  logic [6:0]    mem [0:DEPTH-1];
  logic [6:0]    rdata, wdata;
  logic          we;
  logic [AW-1:0] waddr, raddr;

  logic [RW-1:0] prow, rd_row, base_inc, view_dec;
  logic          printable, in_range, at_last_row, out_free;
  logic [PW-1:0] len_final;
  logic [VW-1:0] vclamp;
  logic [EW-1:0] row_e, view_e, v_e;
  logic [RW-1:0] view_new;

  assign prow        = phys(ring_base, row);
  assign rd_row      = phys(ring_base, rr);
  assign base_inc    = (ring_base == ROW_LAST) ? '0 : ring_base + RW'(1);
  assign view_dec    = (view == '0) ? '0 : view - RW'(1);
  assign printable   = (ch >= CH_SPACE) && (ch <= CH_LAST);
  assign in_range    = (rr <= ROW_LAST) && (rc < COLS_P);
  assign at_last_row = (row == ROW_LAST);
  assign out_free    = !m_tvalid || m_tready;
  assign len_final   = (pend && rdata != CELL_SPACE) ? PW'(pend_col) + PW'(1) : scan_len;
  assign s_tready    = (state == S_IDLE);

  // view window clamp
  assign vclamp = (vis == '0) ? VW'(1) : ((vis > VW'(GRID_ROWS)) ? VW'(GRID_ROWS) : vis);
  assign row_e  = EW'(row);
  assign view_e = EW'(view);
  assign v_e    = EW'(vclamp);
  always_comb begin
    view_new = view;
    if (row < view) begin
      view_new = row;
    end else if (row_e >= view_e + v_e) begin
      view_new = RW'(row_e - v_e + EW'(1));
    end
  end

  // RAM
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

  // next state and RAM port control
  always_comb begin
    state_next = state;
    we    = 1'b0;
    waddr = {prow, put_col};
    wdata = CELL_SPACE;
    raddr = {prow, idx};
    case (state)
      S_CLEAR: begin
        we    = 1'b1;
        waddr = clr_addr;
        if (clr_addr == ADDR_LAST) state_next = clr_reply ? S_DONE : S_IDLE;
      end
      S_IDLE: begin
        if (s_tvalid) state_next = S_DECODE;
      end
      S_DECODE: begin
        raddr      = {rd_row, rc[CW-1:0]};
        state_next = S_DONE;
        case (act)
          ACT_KEY: begin
            if (phase == ESC_SEEN) begin
              state_next = S_DONE;
            end else if (phase == ESC_CSI) begin
              if (ch == NAV_END) state_next = S_SCAN;
            end else if (ch == KEY_ESC) begin
              state_next = S_DONE;
            end else if (ch == KEY_BRK) begin
              if (at_last_row) state_next = S_SCROLL;
            end else if (ch == CH_CR || ch == CH_LF) begin
              state_next = S_SCAN;
            end else if (ch == KEY_BS || ch == KEY_DEL) begin
              if (col != '0) state_next = (col < COLS_P) ? S_SHIFT : S_PUT;
            end else if (ch >= CH_SPACE && ch < KEY_DEL) begin
              if (col < COLS_P) state_next = (col < COL_LASTP) ? S_SHIFT : S_PUT;
            end
          end
          ACT_PUT: begin
            if (ch == CH_LF) begin
              if (at_last_row) state_next = S_SCROLL;
            end else if (ch != CH_CR && ch != KEY_BS && printable) begin
              if (col >= COLS_P && at_last_row) state_next = S_SCROLL;
              else state_next = S_PUT;
            end
          end
          ACT_READ: begin
            if (in_range) state_next = S_READ;
          end
          ACT_CLEAR: begin
            state_next = S_CLEAR;
          end
          default: state_next = S_DONE;
        endcase
      end
      S_SHIFT: begin
        we    = pend;
        waddr = {prow, pend_col};
        wdata = rdata;
        if (idx_last) state_next = S_PUT;
      end
      S_SCAN: begin
        if (idx_last) begin
          if (op == OP_ENTER && at_last_row) state_next = S_SCROLL;
          else state_next = S_DONE;
        end
      end
      S_SCROLL: begin
        we    = 1'b1;
        waddr = {scroll_row, sc_col};
        if (sc_col == COL_LASTC) state_next = (op == OP_PRINT) ? S_PUT : S_DONE;
      end
      S_PUT: begin
        we         = 1'b1;
        wdata      = put_char;
        state_next = S_DONE;
      end
      S_READ: begin
        state_next = S_DONE;
      end
      S_DONE: begin
        if (out_free) state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  // state register
  always_ff @(posedge clk) begin
    if (rst) state <= S_CLEAR;
    else state <= state_next;
  end

  // configuration register
  always_ff @(posedge clk) begin
    if (rst) vis <= VW'(VIS_RESET);
    else if (cfg_wen) vis <= cfg_wdata;
  end

  // datapath and control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      phase     <= ESC_NONE;
      ring_base <= '0;
      row       <= '0;
      col       <= '0;
      view      <= '0;
      clr_addr  <= '0;
      clr_reply <= 1'b0;
      m_tvalid  <= 1'b0;
      pend      <= 1'b0;
      idx_last  <= 1'b0;
    end else begin
      // a new result in the done state replaces the one being taken
      if (m_tvalid && m_tready && state != S_DONE) m_tvalid <= 1'b0;
      case (state)
        S_CLEAR: begin
          clr_addr <= clr_addr + AW'(1);
        end
        S_IDLE: begin
          if (s_tvalid) begin
            act <= action_t'(s_tuser);
            ch  <= s_tdata[7:0];
            rr  <= s_tdata[8 +: RW];
            rc  <= s_tdata[8 + RW +: PW];
          end
        end
        S_DECODE: begin
          res_sub  <= 1'b0;
          res_lrow <= '0;
          res_llen <= '0;
          // out-of-range reads return a space
          res_cell <= (act == ACT_READ && !in_range) ? CELL_SPACE : '0;
          pend     <= 1'b0;
          idx_last <= 1'b0;
          sc_col   <= '0;
          scan_len <= '0;
          case (act)
            ACT_KEY: begin
              if (phase == ESC_SEEN) begin
                phase <= (ch == CH_LBRACK) ? ESC_CSI : ESC_NONE;
              end else if (phase == ESC_CSI) begin
                phase <= ESC_NONE;
                case (ch)
                  NAV_UP:    if (row != '0) row <= row - RW'(1);
                  NAV_DOWN:  if (!at_last_row) row <= row + RW'(1);
                  NAV_RIGHT: if (col < COL_LASTP) col <= col + PW'(1);
                  NAV_LEFT:  if (col != '0) col <= col - PW'(1);
                  NAV_HOME:  col <= '0;
                  NAV_END: begin
                    op  <= OP_END;
                    idx <= '0;
                  end
                  NAV_PGUP: begin
                    row <= (row >= RW'(PAGE_STEP)) ? row - RW'(PAGE_STEP) : '0;
                  end
                  NAV_PGDN: begin
                    if (EW'(row) + EW'(PAGE_STEP) < EW'(GRID_ROWS)) row <= row + RW'(PAGE_STEP);
                    else row <= ROW_LAST;
                  end
                  default: ;
                endcase
              end else if (ch == KEY_ESC) begin
                phase <= ESC_SEEN;
              end else if (ch == KEY_BRK) begin
                col <= '0;
                op  <= OP_LINE;
                if (at_last_row) begin
                  scroll_row <= ring_base;
                  ring_base  <= base_inc;
                  view       <= view_dec;
                end else begin
                  row <= row + RW'(1);
                end
              end else if (ch == CH_CR || ch == CH_LF) begin
                op  <= OP_ENTER;
                idx <= '0;
              end else if (ch == KEY_BS || ch == KEY_DEL) begin
                if (col != '0) begin
                  idx      <= col[CW-1:0];
                  idx_end  <= COL_LASTC;
                  up       <= 1'b1;
                  put_col  <= COL_LASTC;
                  put_char <= CELL_SPACE;
                  col      <= col - PW'(1);
                end else if (row > view) begin
                  row <= row - RW'(1);
                end
              end else if (ch >= CH_SPACE && ch < KEY_DEL) begin
                if (col < COLS_P) begin
                  put_col  <= col[CW-1:0];
                  put_char <= ch[6:0];
                  idx      <= CW'(GRID_COLS - 2);
                  idx_end  <= col[CW-1:0];
                  up       <= 1'b0;
                  if (col < COL_LASTP) col <= col + PW'(1);
                end
              end
            end
            ACT_PUT: begin
              put_char <= ch[6:0];
              if (ch == CH_CR) begin
                col <= '0;
              end else if (ch == CH_LF) begin
                col <= '0;
                op  <= OP_LINE;
                if (at_last_row) begin
                  scroll_row <= ring_base;
                  ring_base  <= base_inc;
                  view       <= view_dec;
                end else begin
                  row <= row + RW'(1);
                end
              end else if (ch == KEY_BS) begin
                if (col != '0) col <= col - PW'(1);
              end else if (printable) begin
                if (col >= COLS_P) begin
                  // wrap to a new line before the write
                  put_col <= '0;
                  col     <= PW'(1);
                  op      <= OP_PRINT;
                  if (at_last_row) begin
                    scroll_row <= ring_base;
                    ring_base  <= base_inc;
                    view       <= view_dec;
                  end else begin
                    row <= row + RW'(1);
                  end
                end else begin
                  put_col <= col[CW-1:0];
                  col     <= col + PW'(1);
                end
              end
            end
            ACT_READ: ;
            ACT_CLEAR: begin
              ring_base <= '0;
              row       <= '0;
              col       <= '0;
              view      <= '0;
              clr_addr  <= '0;
              clr_reply <= 1'b1;
            end
            default: ;
          endcase
        end
        S_SHIFT: begin
          // read one cell ahead, write the previous read one step over
          if (!idx_last) begin
            pend     <= 1'b1;
            pend_col <= up ? idx - CW'(1) : idx + CW'(1);
            if (idx == idx_end) idx_last <= 1'b1;
            else idx <= up ? idx + CW'(1) : idx - CW'(1);
          end else begin
            pend <= 1'b0;
          end
        end
        S_SCAN: begin
          // last non-space column gives the trimmed length
          if (pend && rdata != CELL_SPACE) scan_len <= PW'(pend_col) + PW'(1);
          if (!idx_last) begin
            pend     <= 1'b1;
            pend_col <= idx;
            if (idx == COL_LASTC) idx_last <= 1'b1;
            else idx <= idx + CW'(1);
          end else begin
            pend <= 1'b0;
            if (op == OP_END) begin
              col <= len_final;
            end else begin
              if (len_final != '0) begin
                res_sub  <= 1'b1;
                res_lrow <= at_last_row ? ROW_LAST - RW'(1) : row;
                res_llen <= len_final;
              end
              col <= '0;
              if (at_last_row) begin
                scroll_row <= ring_base;
                ring_base  <= base_inc;
                view       <= view_dec;
              end else begin
                row <= row + RW'(1);
              end
            end
          end
        end
        S_SCROLL: begin
          sc_col <= sc_col + CW'(1);
        end
        S_READ: begin
          res_cell <= rdata;
        end
        S_DONE: begin
          if (out_free) begin
            clr_reply  <= 1'b0;
            view       <= view_new;
            m_tvalid   <= 1'b1;
            m_tdata    <= OUT_W'({res_cell, res_llen, res_lrow, view_new, col, row});
            m_tuser[0] <= res_sub;
          end
        end
        default: ;
      endcase
    end
  end

`ifndef SYNTHESIS
  // cursor row stays on the grid, cursor column at most one past the last column
  assert property (@(posedge clk) disable iff (rst) (row <= ROW_LAST) && (col <= COLS_P))
    else $error("cursor outside grid");

  // ring base stays below the row count
  assert property (@(posedge clk) disable iff (rst) ring_base <= ROW_LAST)
    else $error("ring base out of range");

  // a reported view never starts below the cursor
  assert property (@(posedge clk) disable iff (rst)
    $rose(m_tvalid) |-> (m_tdata[RW + PW +: RW] <= m_tdata[0 +: RW]))
    else $error("view starts below cursor");

  // an accepted item is decoded in the next cycle
  assert property (@(posedge clk) disable iff (rst) (s_tvalid && s_tready) |=> state == S_DECODE)
    else $error("accepted item not decoded");
`endif

endmodule
`default_nettype wire
